[design/soft_knee_compressor_gate_unit_assert.svh]
// Assertion macros for the soft-knee compressor gate unit
`ifndef SOFT_KNEE_COMPRESSOR_GATE_UNIT_ASSERT_SVH
`define SOFT_KNEE_COMPRESSOR_GATE_UNIT_ASSERT_SVH

// same-cycle implication
`define SKCG_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// next-cycle implication
`define SKCG_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

[design/skcg_pkg.sv]
package skcg_pkg;

  localparam int CHANNELS  = 8;
  localparam int CH_W      = 3;
  localparam int CFG_IDX_W = 3;
  localparam int LOG_STEPS = 10;
  localparam int EXP_STEPS = 10;
  localparam int DIV_STEPS = 22;
  localparam logic [15:0] ONE_Q12 = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_HALF_KNEE = 3'd1,
    CFG_RECIP_CR  = 3'd2,
    CFG_GATE      = 3'd3,
    CFG_ATTACK    = 3'd4,
    CFG_RELEASE   = 3'd5
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE     = 5'd0,
    OP_LOAD     = 5'd1,
    OP_LOG_INIT = 5'd2,
    OP_LOG_MUL  = 5'd3,
    OP_LOG_UPD  = 5'd4,
    OP_DIFF     = 5'd5,
    OP_ZERO_T   = 5'd6,
    OP_K_UU     = 5'd7,
    OP_K_RD     = 5'd8,
    OP_K_KD     = 5'd9,
    OP_K_GR     = 5'd10,
    OP_K_SUM    = 5'd11,
    OP_DIV_STEP = 5'd12,
    OP_K_END    = 5'd13,
    OP_LIN_MUL  = 5'd14,
    OP_LIN_END  = 5'd15,
    OP_SM_MUL   = 5'd16,
    OP_SM_END   = 5'd17,
    OP_EXP_INIT = 5'd18,
    OP_EXP_MUL  = 5'd19,
    OP_EXP_UPD  = 5'd20,
    OP_OUT_MUL  = 5'd21,
    OP_OUT_END  = 5'd22
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic       ctrl_zero;
    logic       knee;
    logic [9:0] f;
  } sts_t;

  function automatic logic [30:0] exp_tab(input logic [3:0] k);
    case (k)
      4'd0:    exp_tab = 31'd1518500250;
      4'd1:    exp_tab = 31'd1276901417;
      4'd2:    exp_tab = 31'd1170923762;
      4'd3:    exp_tab = 31'd1121280436;
      4'd4:    exp_tab = 31'd1097253708;
      4'd5:    exp_tab = 31'd1085434106;
      4'd6:    exp_tab = 31'd1079572136;
      4'd7:    exp_tab = 31'd1076653033;
      4'd8:    exp_tab = 31'd1075196443;
      4'd9:    exp_tab = 31'd1074468888;
      default: exp_tab = 31'd1073741824;
    endcase
  endfunction

endpackage

[design/skcg_datapath.sv]
module skcg_datapath
  import skcg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic [2:0]           in_channel,
  input  logic signed [15:0]   in_audio_sample,
  input  logic signed [15:0]   in_control_sample,
  output logic [2:0]           out_channel,
  output logic signed [15:0]   out_sample,
  output logic signed [15:0]   out_gain_response
);

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    if (v > 24'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -24'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  function automatic logic signed [23:0] rnd_sh(input logic signed [35:0] v,
                                                input logic [4:0] sh);
    logic [35:0] mg;
    logic [35:0] r;
    mg = v[35] ? 36'(-v) : 36'(v);
    r  = (mg + (36'd1 << (sh - 5'd1))) >> sh;
    rnd_sh = v[35] ? -$signed(r[23:0]) : $signed(r[23:0]);
  endfunction

  logic signed [15:0] thr_r;
  logic [14:0]        hk_r;
  logic [15:0]        rc_r, gr_r, atk_r, rel_r;
  logic signed [15:0] gain_mem [CHANNELS];

  logic [2:0]         ch_r;
  logic signed [15:0] audio_r, ctrl_r, s_r, t_r, ns_r;
  logic [3:0]         p_r;
  logic [15:0]        x_r;
  logic [9:0]         frac_r, f_r;
  logic signed [17:0] d_r;
  logic signed [65:0] prod_r;
  logic signed [51:0] acc_r;
  logic [51:0]        rem_r, dsh_r;
  logic [21:0]        q_r;
  logic               neg_r;
  logic signed [5:0]  e_r;
  logic [30:0]        m_r;
  logic [2:0]         och_r;
  logic signed [15:0] osmp_r, ogain_r;

  logic signed [16:0] rd;
  logic signed [17:0] kk, u;
  logic               knee;
  logic signed [16:0] cmag;
  logic [3:0]         p_c;
  logic [16:0]        xsq;
  logic signed [17:0] pm, lv;
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [51:0] num;
  logic [51:0]        nmag;
  logic signed [16:0] sdiff, tabs, sabs, amag;
  logic [16:0]        slope;
  logic signed [23:0] qs, kr, smr;
  logic [6:0]         sh;
  logic [63:0]        oq;
  logic [61:0]        mrnd;

  assign rd   = $signed({1'b0, rc_r}) - $signed({1'b0, gr_r});
  assign kk   = $signed({3'b0, hk_r});
  assign u    = d_r + kk;
  assign knee = (d_r > -kk) && (d_r < kk) && (rd != 17'sd0);
  assign cmag = ctrl_r[15] ? -$signed({ctrl_r[15], ctrl_r}) : $signed({ctrl_r[15], ctrl_r});
  assign xsq  = 17'(prod_r[31:15]);
  assign pm   = $signed({14'b0, p_r}) - 18'sd15;
  assign lv   = (pm <<< 10) + $signed({8'b0, frac_r});
  assign num  = acc_r + prod_r[51:0];
  assign nmag = num[51] ? 52'(-num) : 52'(num);
  assign sdiff = $signed({s_r[15], s_r}) - $signed({t_r[15], t_r});
  assign tabs = t_r[15] ? -$signed({t_r[15], t_r}) : $signed({t_r[15], t_r});
  assign sabs = s_r[15] ? -$signed({s_r[15], s_r}) : $signed({s_r[15], s_r});
  assign amag = audio_r[15] ? -$signed({audio_r[15], audio_r})
                            : $signed({audio_r[15], audio_r});
  assign slope = (d_r > 18'sd0) ? 17'({1'b0, rc_r} - {1'b0, ONE_Q12})
                                : 17'({1'b0, gr_r} - {1'b0, ONE_Q12});
  assign qs   = neg_r ? -$signed({2'b0, q_r}) : $signed({2'b0, q_r});
  assign kr   = qs - 24'(d_r);
  assign smr  = 24'(t_r) + rnd_sh(prod_r[35:0], 5'd16);
  assign sh   = 7'd30 - 7'(e_r);
  assign oq   = ({17'd0, prod_r[46:0]} + (64'd1 << (sh - 7'd1))) >> sh;
  assign mrnd = prod_r[61:0] + 62'd536870912;

  always_comb begin
    p_c = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (cmag[i]) begin
        p_c = 4'(i);
      end
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_LOG_MUL: begin
        mul_a = {18'd0, x_r};
        mul_b = {16'd0, x_r};
      end
      OP_K_UU: begin
        mul_a = 34'(u);
        mul_b = 32'(u);
      end
      OP_K_RD: begin
        mul_a = {2'b0, prod_r[31:0]};
        mul_b = 32'(rd);
      end
      OP_K_KD: begin
        mul_a = 34'(kk);
        mul_b = 32'(d_r);
      end
      OP_K_GR: begin
        mul_a = {prod_r[31:0], 2'b0};
        mul_b = {16'd0, gr_r};
      end
      OP_LIN_MUL: begin
        mul_a = 34'(d_r);
        mul_b = 32'($signed(slope));
      end
      OP_SM_MUL: begin
        mul_a = (tabs > sabs) ? {18'd0, atk_r} : {18'd0, rel_r};
        mul_b = 32'(sdiff);
      end
      OP_EXP_MUL: begin
        mul_a = {3'b0, m_r};
        mul_b = {1'b0, exp_tab(cmd.idx[3:0])};
      end
      OP_OUT_MUL: begin
        mul_a = 34'(amag);
        mul_b = {1'b0, m_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      hk_r  <= '0;
      rc_r  <= ONE_Q12;
      gr_r  <= ONE_Q12;
      atk_r <= '0;
      rel_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_r <= cfg_data;
        CFG_HALF_KNEE: hk_r  <= cfg_data[14:0];
        CFG_RECIP_CR:  rc_r  <= cfg_data;
        CFG_GATE:      gr_r  <= cfg_data;
        CFG_ATTACK:    atk_r <= cfg_data;
        CFG_RELEASE:   rel_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        gain_mem[i] <= '0;
      end
    end else if (cmd.op == OP_SM_END && {1'b0, ch_r} < 4'(CHANNELS)) begin
      gain_mem[ch_r[CH_W-1:0]] <= sat16(smr);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        ch_r    <= in_channel;
        audio_r <= in_audio_sample;
        ctrl_r  <= in_control_sample;
        s_r     <= ({1'b0, in_channel} < 4'(CHANNELS)) ?
                   gain_mem[in_channel[CH_W-1:0]] : 16'sd0;
      end
      OP_LOG_INIT: begin
        p_r    <= p_c;
        x_r    <= cmag[15:0] << (4'd15 - p_c);
        frac_r <= '0;
      end
      OP_LOG_UPD: begin
        frac_r <= {frac_r[8:0], xsq[16]};
        x_r    <= xsq[16] ? xsq[16:1] : xsq[15:0];
      end
      OP_DIFF:   d_r <= lv - 18'(thr_r);
      OP_ZERO_T: t_r <= '0;
      OP_K_KD:   acc_r <= prod_r[51:0];
      OP_K_SUM: begin
        neg_r <= num[51];
        rem_r <= nmag + {24'd0, hk_r, 13'd0};
        dsh_r <= {2'b0, hk_r, 35'd0};
        q_r   <= '0;
      end
      OP_DIV_STEP: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[20:0], 1'b1};
        end else begin
          q_r   <= {q_r[20:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
      OP_K_END:   t_r  <= sat16(kr);
      OP_LIN_END: t_r  <= sat16(rnd_sh(prod_r[35:0], 5'd12));
      OP_SM_END:  ns_r <= sat16(smr);
      OP_EXP_INIT: begin
        e_r <= ns_r[15:10];
        f_r <= ns_r[9:0];
        m_r <= 31'd1073741824;
      end
      OP_EXP_UPD: m_r <= mrnd[60:30];
      OP_OUT_END: begin
        och_r   <= ch_r;
        ogain_r <= ns_r;
        if (audio_r == 16'sd0) begin
          osmp_r <= '0;
        end else if (e_r >= 6'sd16) begin
          osmp_r <= audio_r[15] ? 16'sh8000 : 16'sh7fff;
        end else if (!audio_r[15]) begin
          osmp_r <= (oq > 64'd32767) ? 16'sh7fff : oq[15:0];
        end else begin
          osmp_r <= (oq > 64'd32768) ? 16'sh8000 : 16'(-oq[15:0]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOG_MUL, OP_K_UU, OP_K_RD, OP_K_KD, OP_K_GR, OP_LIN_MUL, OP_SM_MUL,
      OP_EXP_MUL, OP_OUT_MUL: prod_r <= mul_a * mul_b;
      default: begin
      end
    endcase
  end

  assign sts.ctrl_zero     = (ctrl_r == 16'sd0);
  assign sts.knee          = knee;
  assign sts.f             = f_r;
  assign out_channel       = och_r;
  assign out_sample        = osmp_r;
  assign out_gain_response = ogain_r;

endmodule

[design/skcg_ctrl.sv]
`include "soft_knee_compressor_gate_unit_assert.svh"

module skcg_ctrl
  import skcg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [26:0] {
    S_IDLE     = 27'd1 << 0,
    S_LOG_INIT = 27'd1 << 1,
    S_LOG_MUL  = 27'd1 << 2,
    S_LOG_UPD  = 27'd1 << 3,
    S_DIFF     = 27'd1 << 4,
    S_CURVE    = 27'd1 << 5,
    S_K_UU     = 27'd1 << 6,
    S_K_RD     = 27'd1 << 7,
    S_K_KD     = 27'd1 << 8,
    S_K_GR     = 27'd1 << 9,
    S_K_SUM    = 27'd1 << 10,
    S_DIV      = 27'd1 << 11,
    S_K_END    = 27'd1 << 12,
    S_LIN_MUL  = 27'd1 << 13,
    S_LIN_END  = 27'd1 << 14,
    S_SM_MUL   = 27'd1 << 15,
    S_SM_END   = 27'd1 << 16,
    S_EXP_INIT = 27'd1 << 17,
    S_EXP_CHK  = 27'd1 << 18,
    S_EXP_MUL  = 27'd1 << 19,
    S_EXP_UPD  = 27'd1 << 20,
    S_OUT_MUL  = 27'd1 << 21,
    S_FIN      = 27'd1 << 22,
    S_SPARE0   = 27'd1 << 23,
    S_SPARE1   = 27'd1 << 24,
    S_SPARE2   = 27'd1 << 25,
    S_SPARE3   = 27'd1 << 26
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] fidx;

  assign fidx = 4'd9 - cnt_r[3:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.idx       = cnt_r;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_LOG_INIT;
        end
      end
      S_LOG_INIT: begin
        cnt_nxt = '0;
        if (sts.ctrl_zero) begin
          cmd.op    = OP_ZERO_T;
          state_nxt = S_SM_MUL;
        end else begin
          cmd.op    = OP_LOG_INIT;
          state_nxt = S_LOG_MUL;
        end
      end
      S_LOG_MUL: begin
        cmd.op    = OP_LOG_MUL;
        state_nxt = S_LOG_UPD;
      end
      S_LOG_UPD: begin
        cmd.op  = OP_LOG_UPD;
        cnt_nxt = cnt_r + 5'd1;
        state_nxt = (cnt_r == 5'(LOG_STEPS - 1)) ? S_DIFF : S_LOG_MUL;
      end
      S_DIFF: begin
        cmd.op    = OP_DIFF;
        state_nxt = S_CURVE;
      end
      S_CURVE: state_nxt = sts.knee ? S_K_UU : S_LIN_MUL;
      S_K_UU: begin
        cmd.op    = OP_K_UU;
        state_nxt = S_K_RD;
      end
      S_K_RD: begin
        cmd.op    = OP_K_RD;
        state_nxt = S_K_KD;
      end
      S_K_KD: begin
        cmd.op    = OP_K_KD;
        state_nxt = S_K_GR;
      end
      S_K_GR: begin
        cmd.op    = OP_K_GR;
        state_nxt = S_K_SUM;
      end
      S_K_SUM: begin
        cmd.op    = OP_K_SUM;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = S_K_END;
        end
      end
      S_K_END: begin
        cmd.op    = OP_K_END;
        state_nxt = S_SM_MUL;
      end
      S_LIN_MUL: begin
        cmd.op    = OP_LIN_MUL;
        state_nxt = S_LIN_END;
      end
      S_LIN_END: begin
        cmd.op    = OP_LIN_END;
        state_nxt = S_SM_MUL;
      end
      S_SM_MUL: begin
        cmd.op    = OP_SM_MUL;
        state_nxt = S_SM_END;
      end
      S_SM_END: begin
        cmd.op    = OP_SM_END;
        state_nxt = S_EXP_INIT;
      end
      S_EXP_INIT: begin
        cmd.op    = OP_EXP_INIT;
        cnt_nxt   = '0;
        state_nxt = S_EXP_CHK;
      end
      S_EXP_CHK: begin
        if (sts.f[fidx]) begin
          state_nxt = S_EXP_MUL;
        end else if (cnt_r == 5'(EXP_STEPS - 1)) begin
          state_nxt = S_OUT_MUL;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_EXP_MUL: begin
        cmd.op    = OP_EXP_MUL;
        state_nxt = S_EXP_UPD;
      end
      S_EXP_UPD: begin
        cmd.op = OP_EXP_UPD;
        if (cnt_r == 5'(EXP_STEPS - 1)) begin
          state_nxt = S_OUT_MUL;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = S_EXP_CHK;
        end
      end
      S_OUT_MUL: begin
        cmd.op    = OP_OUT_MUL;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_OUT_END;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `SKCG_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready, "accepted while busy")
  `SKCG_ASSERT_NEXT(a_fin_waits, state_r == S_FIN && out_valid_r && !out_ready, state_r == S_FIN, "result overwritten")
  `SKCG_ASSERT_NOW(a_div_bound, cmd.op == OP_DIV_STEP, cnt_r < 5'(DIV_STEPS), "divider overrun")

endmodule

[design/soft_knee_compressor_gate_unit.sv]
// Per-channel soft-knee compressor with expander gate. Each transfer brings a channel, an
// audio sample and a side-chain sample (Q1.15); the result gives the scaled audio and the
// smoothed gain (Q6.10). One item is processed at a time on a single shared multiplier,
// through the 10-step log2 squaring loop, the 22-step knee divider (knee only) and up
// to 10 exponent multiplies; a zero side-chain sample skips the log and knee steps.
// The result register lets the next item enter while a result waits. Configuration
// writes take effect at once, must be made only while the unit is idle (not enforced).
module soft_knee_compressor_gate_unit
  import skcg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_channel,
  input  logic signed [15:0]   in_audio_sample,
  input  logic signed [15:0]   in_control_sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_channel,
  output logic signed [15:0]   out_sample,
  output logic signed [15:0]   out_gain_response
);

  cmd_t cmd;
  sts_t sts;

  skcg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  skcg_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_channel        (in_channel),
    .in_audio_sample   (in_audio_sample),
    .in_control_sample (in_control_sample),
    .out_channel       (out_channel),
    .out_sample        (out_sample),
    .out_gain_response (out_gain_response)
  );

endmodule
